@@ rtl/pcwm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcwm_pkg: shared types and constants
// Pattern sizing, register indexes, window settings and byte folding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pcwm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_STORED  = 16;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_MODIFIER_FLAGS = 3'd3,
    CFG_FIXED_OFFSET   = 3'd4,
    CFG_DEPTH_LIMIT    = 3'd5,
    CFG_DISTANCE_GAP   = 3'd6,
    CFG_WITHIN_LIMIT   = 3'd7
  } cfg_index_t;

  // Window settings handed to the window builder
  typedef struct packed {
    logic        offset_en;
    logic        depth_en;
    logic        distance_en;
    logic        within_en;
    logic [15:0] fixed_offset;
    logic [15:0] depth_limit;
    logic [15:0] distance_gap;
    logic [15:0] within_limit;
  } win_cfg_t;

  // Map upper-case ASCII to lower case when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic nocase);
    logic [7:0] r;
    r = c;
    if (nocase && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pcwm_window.sv @@
// ----------------------------------------------------------------------------
// pcwm_window: search window builder
// Applies offset, depth, distance and within, in that order, to the prior offset.
// ----------------------------------------------------------------------------
`default_nettype none

module pcwm_window (
  input  wire logic [15:0]        prior,
  input  wire pcwm_pkg::win_cfg_t cfg,
  output logic      [16:0]        win_start,
  output logic      [17:0]        win_end
);

  logic [15:0] base;

  always_comb begin
    base      = cfg.offset_en ? cfg.fixed_offset : prior;
    win_end   = '1;
    if (cfg.depth_en) begin
      win_end = 18'(base) + 18'(cfg.depth_limit);
    end
    // distance moves the start only when there is a prior offset
    if (cfg.distance_en && (prior != 16'd0)) begin
      win_start = 17'(prior) + 17'(cfg.distance_gap);
    end else begin
      win_start = 17'(base);
    end
    if (cfg.within_en) begin
      win_end = 18'(win_start) + 18'(cfg.within_limit);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pcwm_compare.sv @@
// ----------------------------------------------------------------------------
// pcwm_compare: pattern compare lanes
// Compares the newest bytes against the pattern, one lane per pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pcwm_compare (
  input  wire logic [7:0]                 recent [pcwm_pkg::MAX_PATTERN],
  input  wire logic [127:0]               pattern,
  input  wire logic [pcwm_pkg::LEN_W-1:0] len,
  input  wire logic                       nocase,
  output logic                            equal
);

  logic [7:0]                       pbyte [pcwm_pkg::MAX_PATTERN];
  logic [pcwm_pkg::MAX_PATTERN-1:0] lane_ok;
  logic [pcwm_pkg::LEN_W-1:0]       pidx;

  // bytes past the stored pattern read as zero
  always_comb begin
    for (int k = 0; k < pcwm_pkg::MAX_PATTERN; k++) begin
      if (k < pcwm_pkg::PAT_STORED) begin
        pbyte[k] = pattern[8*(k % pcwm_pkg::PAT_STORED) +: 8];
      end else begin
        pbyte[k] = 8'h00;
      end
    end
  end

  // recent[j] lines up with pattern byte len-1-j
  always_comb begin
    pidx = '0;
    for (int j = 0; j < pcwm_pkg::MAX_PATTERN; j++) begin
      pidx = len - pcwm_pkg::LEN_W'(j + 1);
      if (pcwm_pkg::LEN_W'(j) < len) begin
        lane_ok[j] = pcwm_pkg::fold_byte(recent[j], nocase) ==
                     pcwm_pkg::fold_byte(pbyte[pidx[pcwm_pkg::IDX_W-1:0]], nocase);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
    equal = &lane_ok;
  end

endmodule

`default_nettype wire

@@ rtl/payload_content_window_match.sv @@
// ----------------------------------------------------------------------------
// payload_content_window_match: windowed payload content matcher
// Finds the leftmost pattern occurrence inside a modifier-built window.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one payload beat per byte, in_last_byte marks the final byte and
//           in_prior_offset is sampled with the first byte of each payload.
//   out_* : one beat per payload, issued for the final byte: out_matched and
//           out_next_offset (match end, or the prior offset on a miss).
//   cfg_* : register writes, always ready; write only while the block idles.
// Timing: a byte beat is registered, then compared against the pattern and
//   the result lands in the output register; out_valid rises once the final
//   byte has left the input register. One byte is taken per cycle unless a
//   final byte waits on the output slot; the compare and window update sit
//   between the input register and the output register.
// Stall: while a result waits on out_ready, non-final bytes keep flowing;
//   a final byte holds in the input register until the output slot frees.
// Reset: rst_n low clears the pipeline, the byte history, the position and
//   the registers to their defaults (pattern length 1, all others zero).
// ----------------------------------------------------------------------------
`default_nettype none

module payload_content_window_match (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [15:0] in_prior_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_matched,
  output logic      [15:0] out_next_offset,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int MP = pcwm_pkg::MAX_PATTERN;
  localparam int LW = pcwm_pkg::LEN_W;

  // Configuration registers
  logic [63:0] cfg_pat_lo_r, cfg_pat_hi_r;
  logic [4:0]  cfg_plen_r, cfg_flags_r;
  logic [15:0] cfg_fixed_r, cfg_depth_r, cfg_gap_r, cfg_within_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pat_lo_r <= '0;
      cfg_pat_hi_r <= '0;
      cfg_plen_r   <= 5'd1;
      cfg_flags_r  <= '0;
      cfg_fixed_r  <= '0;
      cfg_depth_r  <= '0;
      cfg_gap_r    <= '0;
      cfg_within_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcwm_pkg::cfg_index_t'(cfg_index))
        pcwm_pkg::CFG_PATTERN_LOW:    cfg_pat_lo_r <= cfg_data;
        pcwm_pkg::CFG_PATTERN_HIGH:   cfg_pat_hi_r <= cfg_data;
        pcwm_pkg::CFG_PATTERN_LENGTH: cfg_plen_r   <= cfg_data[4:0];
        pcwm_pkg::CFG_MODIFIER_FLAGS: cfg_flags_r  <= cfg_data[4:0];
        pcwm_pkg::CFG_FIXED_OFFSET:   cfg_fixed_r  <= cfg_data[15:0];
        pcwm_pkg::CFG_DEPTH_LIMIT:    cfg_depth_r  <= cfg_data[15:0];
        pcwm_pkg::CFG_DISTANCE_GAP:   cfg_gap_r    <= cfg_data[15:0];
        pcwm_pkg::CFG_WITHIN_LIMIT:   cfg_within_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [15:0] s1_prior_r;
  logic        s1_adv;
  logic        out_valid_r;

  // a final byte needs the output slot; other bytes never wait on it
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_data_byte;
      s1_last_r  <= in_last_byte;
      s1_prior_r <= in_prior_offset;
    end
  end

  // Per-payload match state
  logic [7:0]  recent_r [MP];
  logic [7:0]  recent_nxt [MP];
  logic [15:0] pos_r, pos_nxt;
  logic [16:0] win_start_r, win_start_nxt;
  logic [17:0] win_end_r, win_end_nxt;
  logic        found_r, found_nxt;
  logic [15:0] found_end_r, found_end_nxt;
  logic [15:0] held_prior_r, held_prior_nxt;

  pcwm_pkg::win_cfg_t win_cfg;
  logic [16:0]        built_start;
  logic [17:0]        built_end;
  logic [LW-1:0]      len_eff;
  logic               pat_equal;
  logic               first;
  logic [16:0]        pos_p1;
  logic [16:0]        span_start;
  logic               span_in;
  logic               hit;

  assign win_cfg.offset_en    = cfg_flags_r[0];
  assign win_cfg.depth_en     = cfg_flags_r[1];
  assign win_cfg.distance_en  = cfg_flags_r[2];
  assign win_cfg.within_en    = cfg_flags_r[3];
  assign win_cfg.fixed_offset = cfg_fixed_r;
  assign win_cfg.depth_limit  = cfg_depth_r;
  assign win_cfg.distance_gap = cfg_gap_r;
  assign win_cfg.within_limit = cfg_within_r;

  pcwm_window u_window (
    .prior     (s1_prior_r),
    .cfg       (win_cfg),
    .win_start (built_start),
    .win_end   (built_end)
  );

  // clamp the length to the lane count
  assign len_eff = (6'(cfg_plen_r) > 6'(MP)) ? LW'(MP) : LW'(cfg_plen_r);

  // shift the newest byte into the history
  always_comb begin
    recent_nxt[0] = s1_byte_r;
    for (int i = 1; i < MP; i++) begin
      recent_nxt[i] = recent_r[i-1];
    end
  end

  pcwm_compare u_compare (
    .recent  (recent_nxt),
    .pattern ({cfg_pat_hi_r, cfg_pat_lo_r}),
    .len     (len_eff),
    .nocase  (cfg_flags_r[4]),
    .equal   (pat_equal)
  );

  always_comb begin
    first          = (pos_r == 16'd0);
    held_prior_nxt = first ? s1_prior_r  : held_prior_r;
    win_start_nxt  = first ? built_start : win_start_r;
    win_end_nxt    = first ? built_end   : win_end_r;

    pos_p1     = 17'(pos_r) + 17'd1;
    span_start = pos_p1 - 17'(len_eff);
    span_in    = (len_eff != '0) && (pos_p1 >= 17'(len_eff)) &&
                 (span_start >= win_start_nxt) && (18'(pos_p1) <= win_end_nxt);
    hit        = !found_r && span_in && pat_equal;

    found_nxt     = found_r || hit;
    found_end_nxt = found_end_r;
    if (hit) begin
      // match end past the position range saturates
      found_end_nxt = pos_p1[16] ? pcwm_pkg::POS_MAX : pos_p1[15:0];
    end

    pos_nxt = (pos_r == pcwm_pkg::POS_MAX) ? pos_r : pos_p1[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MP; i++) begin
        recent_r[i] <= '0;
      end
      pos_r        <= '0;
      win_start_r  <= '0;
      win_end_r    <= '0;
      found_r      <= 1'b0;
      found_end_r  <= '0;
      held_prior_r <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < MP; i++) begin
        recent_r[i] <= recent_nxt[i];
      end
      win_start_r  <= win_start_nxt;
      win_end_r    <= win_end_nxt;
      held_prior_r <= held_prior_nxt;
      if (s1_last_r) begin
        // drop the payload state for the next packet
        pos_r       <= '0;
        found_r     <= 1'b0;
        found_end_r <= '0;
      end else begin
        pos_r       <= pos_nxt;
        found_r     <= found_nxt;
        found_end_r <= found_end_nxt;
      end
    end
  end

  // Output register
  logic        out_matched_r;
  logic [15:0] out_next_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_matched_r     <= found_nxt;
      out_next_offset_r <= found_nxt ? found_end_nxt : held_prior_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_next_offset = out_next_offset_r;

  // Checks
  a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> pos_r == 16'd0)
    else $error("position not cleared after final byte");

  a_found_inside_payload: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> pos_r != 16'd0)
    else $error("match flag held outside a payload");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> s1_last_r && out_valid_r && !out_ready)
    else $error("input stage stalled without a blocked result");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result issued without a final byte");

endmodule

`default_nettype wire

@@ tb/tb_payload_content_window_match.sv @@
// ----------------------------------------------------------------------------
// tb_payload_content_window_match: self-checking bench for the window matcher
// Streams payload bytes through the matcher with random gaps on both sides,
// predicts the match flag and next offset of every payload, and checks each
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_payload_content_window_match;
  timeunit 1ns;
  timeprecision 1ps;

  // Bit positions inside the modifier register
  localparam int FLAG_OFFSET   = 0;
  localparam int FLAG_DEPTH    = 1;
  localparam int FLAG_DISTANCE = 2;
  localparam int FLAG_WITHIN   = 3;
  localparam int FLAG_NOCASE   = 4;

  // Window end used when neither depth nor within bounds the search
  localparam logic [17:0] OPEN_END = 18'h3FFFF;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] prior;
  } byte_beat_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] next_offset;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic [15:0] in_prior_offset = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_matched;
  logic [15:0] out_next_offset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  pcwm_pkg::cfg_index_t cfg_index = pcwm_pkg::CFG_PATTERN_LOW;
  logic [63:0] cfg_data = 64'h0;

  payload_content_window_match dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_prior_offset (in_prior_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_matched     (out_matched),
    .out_next_offset (out_next_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be driven, and the verdicts the matcher still owes us
  byte_beat_t  pending_bytes[$];
  verdict_t    expected_verdicts[$];
  logic [7:0]  payload_buf[$];

  int          snd_idle_pct = 18;
  int          rcv_idle_pct = 83;
  int          fail_count = 0;
  logic        in_taken = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor: shadow registers and matcher state
  // --------------------------------------------------------------------------
  logic [63:0] m_pat_lo, m_pat_hi;
  logic [4:0]  m_pat_len, m_flags;
  logic [15:0] m_fixed, m_depth, m_gap, m_within;
  logic [7:0]  m_hist[pcwm_pkg::MAX_PATTERN];
  logic [15:0] m_pos;
  logic [16:0] m_win_lo;
  logic [17:0] m_win_hi;
  logic        m_found;
  logic [15:0] m_found_end;
  logic [15:0] m_prior;

  function automatic logic [7:0] lower_ascii(logic [7:0] c, logic nocase);
    if (nocase && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned k);
    if (k < 8) return m_pat_lo[8*k +: 8];
    if (k < 16) return m_pat_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic void clear_matcher();
    m_pat_lo = '0;
    m_pat_hi = '0;
    m_pat_len = 5'd1;
    m_flags = '0;
    m_fixed = '0;
    m_depth = '0;
    m_gap = '0;
    m_within = '0;
    for (int i = 0; i < pcwm_pkg::MAX_PATTERN; i++) m_hist[i] = 8'h00;
    m_pos = '0;
    m_win_lo = '0;
    m_win_hi = '0;
    m_found = 1'b0;
    m_found_end = '0;
    m_prior = '0;
  endfunction

  function automatic void load_register(pcwm_pkg::cfg_index_t idx, logic [63:0] val);
    case (idx)
      pcwm_pkg::CFG_PATTERN_LOW:    m_pat_lo = val;
      pcwm_pkg::CFG_PATTERN_HIGH:   m_pat_hi = val;
      pcwm_pkg::CFG_PATTERN_LENGTH: m_pat_len = val[4:0];
      pcwm_pkg::CFG_MODIFIER_FLAGS: m_flags = val[4:0];
      pcwm_pkg::CFG_FIXED_OFFSET:   m_fixed = val[15:0];
      pcwm_pkg::CFG_DEPTH_LIMIT:    m_depth = val[15:0];
      pcwm_pkg::CFG_DISTANCE_GAP:   m_gap = val[15:0];
      pcwm_pkg::CFG_WITHIN_LIMIT:   m_within = val[15:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow matcher by one accepted byte; queue a verdict on the
  // final byte of a payload.
  function automatic void match_step(byte_beat_t b);
    int unsigned lo, hi, len, span_lo, span_hi;
    logic        same;
    verdict_t    v;
    if (m_pos == 0) begin
      // Build the window once per payload: offset, depth, distance, within
      m_prior = b.prior;
      lo = b.prior;
      hi = OPEN_END;
      if (m_flags[FLAG_OFFSET]) lo = m_fixed;
      if (m_flags[FLAG_DEPTH]) hi = lo + m_depth;
      if (m_flags[FLAG_DISTANCE] && b.prior != 0) lo = b.prior + m_gap;
      if (m_flags[FLAG_WITHIN]) hi = lo + m_within;
      m_win_lo = lo[16:0];
      m_win_hi = hi[17:0];
    end
    for (int i = pcwm_pkg::MAX_PATTERN - 1; i > 0; i--) m_hist[i] = m_hist[i-1];
    m_hist[0] = b.data;
    len = (m_pat_len > pcwm_pkg::MAX_PATTERN) ? pcwm_pkg::MAX_PATTERN : m_pat_len;
    if (!m_found && len != 0 && m_pos + 1 >= len) begin
      span_lo = m_pos + 1 - len;
      span_hi = m_pos + 1;
      if (span_lo >= m_win_lo && span_hi <= m_win_hi) begin
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (lower_ascii(m_hist[len-1-k], m_flags[FLAG_NOCASE]) !=
              lower_ascii(pattern_at(k), m_flags[FLAG_NOCASE])) same = 1'b0;
        end
        if (same) begin
          m_found = 1'b1;
          m_found_end = (span_hi > pcwm_pkg::POS_MAX) ? pcwm_pkg::POS_MAX : span_hi[15:0];
        end
      end
    end
    if (m_pos != pcwm_pkg::POS_MAX) m_pos++;
    if (b.last) begin
      v.matched = m_found;
      v.next_offset = m_found ? m_found_end : m_prior;
      expected_verdicts.push_back(v);
      m_pos = '0;
      m_found = 1'b0;
      m_found_end = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present byte beats at the falling edge, hold until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : byte_driver
    byte_beat_t nxt;
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= nxt.data;
        in_last_byte <= nxt.last;
        in_prior_offset <= nxt.prior;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample all three channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    verdict_t   want;
    byte_beat_t got;
    in_taken <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      clear_matcher();
    end else begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      // Check the result beat against the oldest verdict first
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual matched %0d offset %0d",
                   $time, out_matched, out_next_offset);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_matched !== want.matched) begin
            $display("%0t: out_matched expected %0d actual %0d",
                     $time, want.matched, out_matched);
            fail_count++;
          end
          if (out_next_offset !== want.next_offset) begin
            $display("%0t: out_next_offset expected %0d actual %0d",
                     $time, want.next_offset, out_next_offset);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got.data = in_data_byte;
        got.last = in_last_byte;
        got.prior = in_prior_offset;
        match_step(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Move the assembled payload into the driver queue; only the first beat
  // carries the real prior offset, the others carry junk that must be ignored.
  task automatic push_payload(logic [15:0] prior);
    byte_beat_t b;
    for (int i = 0; i < payload_buf.size(); i++) begin
      b.data = payload_buf[i];
      b.last = (i == payload_buf.size() - 1);
      b.prior = (i == 0) ? prior : 16'($urandom_range(65535));
      pending_bytes.push_back(b);
    end
    payload_buf.delete();
  endtask

  task automatic send_text(string s, logic [15:0] prior);
    for (int i = 0; i < s.len(); i++) payload_buf.push_back(s[i]);
    push_payload(prior);
  endtask

  task automatic write_reg(pcwm_pkg::cfg_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                           logic [4:0] flags, logic [15:0] off, logic [15:0] dep,
                           logic [15:0] gap, logic [15:0] win);
    write_reg(pcwm_pkg::CFG_PATTERN_LOW, lo);
    write_reg(pcwm_pkg::CFG_PATTERN_HIGH, hi);
    write_reg(pcwm_pkg::CFG_PATTERN_LENGTH, {59'h0, len});
    write_reg(pcwm_pkg::CFG_MODIFIER_FLAGS, {59'h0, flags});
    write_reg(pcwm_pkg::CFG_FIXED_OFFSET, {48'h0, off});
    write_reg(pcwm_pkg::CFG_DEPTH_LIMIT, {48'h0, dep});
    write_reg(pcwm_pkg::CFG_DISTANCE_GAP, {48'h0, gap});
    write_reg(pcwm_pkg::CFG_WITHIN_LIMIT, {48'h0, win});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the matcher to go quiet: every byte taken, every verdict seen,
  // then let the two-stage pipeline settle.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] lo_word, hi_word;
    logic [4:0]  len_v, flag_v;
    logic [15:0] off_v, dep_v, gap_v, win_v, prior_v;
    logic [7:0]  c;
    int unsigned eff_len, plen, at, pick, copy_len, phase_items;
    string       letters;
    letters = "aAbBcC";

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: one-byte pattern 0x00, window from the prior offset
    payload_buf.push_back(8'h00);
    push_payload(16'h0000);
    payload_buf.push_back(8'hFF);
    push_payload(16'hFFFF);
    drain();

    // Case folding hit, then a payload shorter than the pattern
    configure(64'h0000_0000_0043_6241, 64'h0, 5'd3, 5'(1 << FLAG_NOCASE),
              16'd0, 16'd0, 16'd0, 16'd0);
    send_text("xaBcz", 16'd0);
    send_text("ab", 16'd7);
    drain();

    // All four window modifiers; distance moves the start only when the
    // prior offset is nonzero, so the second payload keeps the fixed start
    configure(64'h0000_0000_0043_6241, 64'h0, 5'd3,
              5'((1 << FLAG_OFFSET) | (1 << FLAG_DEPTH) | (1 << FLAG_DISTANCE) |
                 (1 << FLAG_WITHIN)),
              16'd2, 16'd5, 16'd1, 16'd4);
    send_text("AbCxAbCx", 16'd3);
    send_text("xxAbCx", 16'd0);
    drain();

    for (int p = 1; p <= 9; p++) begin
      // Receiver-heavy gaps, then sender-heavy, then full rate
      if (p <= 3) begin
        snd_idle_pct = 18;
        rcv_idle_pct = 83;
      end else if (p <= 6) begin
        snd_idle_pct = 83;
        rcv_idle_pct = 18;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      if ($urandom_range(2) == 0) begin
        lo_word = {$urandom, $urandom};
        hi_word = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 8; k++) begin
          lo_word[8*k +: 8] = letters[$urandom_range(letters.len() - 1)];
          hi_word[8*k +: 8] = letters[$urandom_range(letters.len() - 1)];
        end
      end
      len_v = ($urandom_range(3) == 0) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(1, 4));
      flag_v = 5'($urandom_range(31));
      off_v = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(20));
      dep_v = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(24));
      gap_v = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(12));
      win_v = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(24));
      // Pin a few phases to the corners: full pattern, zero length,
      // oversized length, all-ones and all-zeros registers
      case (p)
        1: len_v = 5'd16;
        2: len_v = 5'd0;
        3: len_v = 5'd31;
        4: begin
          lo_word = '1;
          hi_word = '1;
          flag_v = '1;
          off_v = '1;
          dep_v = '1;
          gap_v = '1;
          win_v = '1;
        end
        5: begin
          lo_word = '0;
          hi_word = '0;
          off_v = '0;
          dep_v = '0;
          gap_v = '0;
          win_v = '0;
        end
        default: ;
      endcase
      configure(lo_word, hi_word, len_v, flag_v, off_v, dep_v, gap_v, win_v);

      phase_items = 0;
      while (phase_items < 112) begin
        plen = $urandom_range(1, 24);
        eff_len = (m_pat_len > pcwm_pkg::MAX_PATTERN) ? pcwm_pkg::MAX_PATTERN : m_pat_len;
        pick = $urandom_range(9);
        // Fill with pattern-like bytes, or pure noise for a fifth of payloads
        for (int i = 0; i < plen; i++) begin
          if (pick < 2) c = 8'($urandom_range(255));
          else if (eff_len != 0 && $urandom_range(1)) c = pattern_at($urandom_range(eff_len - 1));
          else c = letters[$urandom_range(letters.len() - 1)];
          payload_buf.push_back(c);
        end
        // Plant a copy of the pattern; a broken copy drops its last byte
        if (pick >= 3 && eff_len != 0 && plen >= eff_len) begin
          at = $urandom_range(plen - eff_len);
          copy_len = (pick == 3) ? eff_len - 1 : eff_len;
          for (int k = 0; k < copy_len; k++) begin
            c = pattern_at(k);
            if (m_flags[FLAG_NOCASE] && $urandom_range(1)) c = flip_case(c);
            payload_buf[at + k] = c;
          end
        end
        case ($urandom_range(3))
          0: prior_v = 16'($urandom_range(65535));
          1: prior_v = 16'd0;
          default: prior_v = 16'($urandom_range(12));
        endcase
        push_payload(prior_v);
        phase_items += plen;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_payload_content_window_match passed");
    end else begin
      $display("tb_payload_content_window_match failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("tb_payload_content_window_match failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcwm_pkg.sv
rtl/pcwm_window.sv
rtl/pcwm_compare.sv
rtl/payload_content_window_match.sv
tb/tb_payload_content_window_match.sv
